@@ rtl/gcwp_pkg.sv @@
// ----------------------------------------------------------------------------
// gcwp_pkg
// Shared types and constants for the G/C window profiler.
// ----------------------------------------------------------------------------
`default_nettype none

package gcwp_pkg;

    localparam int POSITION_BITS_DEF = 32;

    localparam int BASE_W  = 8;
    localparam int WIN_W   = 16;
    localparam int IDX_W   = 32;
    localparam int SUM_W   = 32;
    localparam int SQ_W    = 48;
    localparam int OUTPOS_W = 32;

    localparam logic [BASE_W-1:0] BASE_N = 8'h4E;
    localparam logic [BASE_W-1:0] BASE_G = 8'h47;
    localparam logic [BASE_W-1:0] BASE_C = 8'h43;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [SQ_W-1:0]  SQ_MAX  = {SQ_W{1'b1}};

    // Result queue: a beat is processed only while two slots are free, so
    // both results of one base always fit.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic
    {
        KIND_WINDOW = 1'b0,
        KIND_RUN    = 1'b1
    } kind_t;

    typedef struct packed
    {
        kind_t                  kind;
        logic [IDX_W-1:0]       window_index;
        logic [WIN_W-1:0]       window_gc_count;
        logic [SUM_W-1:0]       gc_running_sum;
        logic [SQ_W-1:0]        gc_square_sum;
        logic [OUTPOS_W-1:0]    run_start;
        logic [OUTPOS_W-1:0]    run_end;
        logic                   last_of_run;
    } result_t;

    // Up to two results produced by one base; slot 1 is used only with slot 0.
    typedef struct packed
    {
        logic    valid0;
        logic    valid1;
        result_t res0;
        result_t res1;
    } res_push_t;

endpackage

`default_nettype wire

@@ rtl/gcwp_core.sv @@
// ----------------------------------------------------------------------------
// gcwp_core
// Sequence state and per-base result formation.
// ----------------------------------------------------------------------------
`default_nettype none

module gcwp_core #(
    parameter int POSITION_BITS = gcwp_pkg::POSITION_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          fire,
    input  wire logic [gcwp_pkg::BASE_W-1:0]   base,
    input  wire logic                          end_of_sequence,
    input  wire logic [gcwp_pkg::WIN_W-1:0]    window_length,
    output gcwp_pkg::res_push_t                push
);

    logic [POSITION_BITS-1:0]          position_reg, position_next;
    logic [POSITION_BITS-1:0]          run_begin_reg, run_begin_next;
    logic [POSITION_BITS-1:0]          pos_inc;
    logic [POSITION_BITS-1:0]          run_start_pos, run_end_pos;
    logic                              in_run_reg, in_run_next;
    logic [gcwp_pkg::WIN_W-1:0]        bases_reg, bases_next;
    logic [gcwp_pkg::WIN_W-1:0]        gc_reg, gc_next;
    logic [gcwp_pkg::WIN_W-1:0]        bases_inc, gc_inc, wl_eff;
    logic [gcwp_pkg::IDX_W-1:0]        windows_reg, windows_next;
    logic [gcwp_pkg::SUM_W-1:0]        total_reg, total_next, total_sat;
    logic [gcwp_pkg::SQ_W-1:0]         sq_reg, sq_next, sq_sat;
    logic [gcwp_pkg::SUM_W:0]          total_sum;
    logic [2*gcwp_pkg::WIN_W-1:0]      gc_square;
    logic [gcwp_pkg::SQ_W:0]           sq_sum;
    logic                              is_n, is_gc, win_done, run_close;
    gcwp_pkg::result_t                 run_res, win_res;

    assign is_n  = (base == gcwp_pkg::BASE_N);
    assign is_gc = (base == gcwp_pkg::BASE_G) || (base == gcwp_pkg::BASE_C);

    assign pos_inc   = position_reg + {{(POSITION_BITS-1){1'b0}}, 1'b1};
    assign wl_eff    = (window_length == '0) ? 16'd1 : window_length;
    assign bases_inc = bases_reg + 16'd1;
    assign gc_inc    = gc_reg + {15'd0, is_gc};
    assign win_done  = !is_n && (bases_inc == wl_eff);
    assign run_close = is_n ? end_of_sequence : in_run_reg;

    assign total_sum = {1'b0, total_reg} + {17'd0, gc_inc};
    assign total_sat = total_sum[gcwp_pkg::SUM_W] ? gcwp_pkg::SUM_MAX
                                                  : total_sum[gcwp_pkg::SUM_W-1:0];
    assign gc_square = {16'd0, gc_inc} * {16'd0, gc_inc};
    assign sq_sum    = {1'b0, sq_reg} + {17'd0, gc_square};
    assign sq_sat    = sq_sum[gcwp_pkg::SQ_W] ? gcwp_pkg::SQ_MAX
                                              : sq_sum[gcwp_pkg::SQ_W-1:0];

    // A run opened by this very N base starts at the current position.
    assign run_start_pos = (is_n && !in_run_reg) ? position_reg : run_begin_reg;
    assign run_end_pos   = is_n ? pos_inc : position_reg;

    always_comb
    begin
        run_res                 = '0;
        run_res.kind            = gcwp_pkg::KIND_RUN;
        run_res.run_start       = 32'(run_start_pos);
        run_res.run_end         = 32'(run_end_pos);

        win_res                 = '0;
        win_res.kind            = gcwp_pkg::KIND_WINDOW;
        win_res.window_index    = windows_reg;
        win_res.window_gc_count = gc_inc;
        win_res.gc_running_sum  = total_sat;
        win_res.gc_square_sum   = sq_sat;
        win_res.last_of_run     = 1'b1;

        push.valid0           = fire && (run_close || win_done);
        push.valid1           = fire && run_close && win_done;
        push.res0             = run_close ? run_res : win_res;
        push.res0.last_of_run = !(run_close && win_done);
        push.res1             = win_res;
    end

    always_comb
    begin
        position_next  = position_reg;
        run_begin_next = run_begin_reg;
        in_run_next    = in_run_reg;
        bases_next     = bases_reg;
        gc_next        = gc_reg;
        windows_next   = windows_reg;
        total_next     = total_reg;
        sq_next        = sq_reg;
        if (fire)
        begin
            if (end_of_sequence)
            begin
                position_next  = '0;
                run_begin_next = '0;
                in_run_next    = 1'b0;
                bases_next     = '0;
                gc_next        = '0;
                windows_next   = '0;
                total_next     = '0;
                sq_next        = '0;
            end
            else if (is_n)
            begin
                in_run_next    = 1'b1;
                run_begin_next = run_start_pos;
                position_next  = pos_inc;
            end
            else
            begin
                in_run_next   = 1'b0;
                position_next = pos_inc;
                if (win_done)
                begin
                    bases_next   = '0;
                    gc_next      = '0;
                    windows_next = windows_reg + 32'd1;
                    total_next   = total_sat;
                    sq_next      = sq_sat;
                end
                else
                begin
                    bases_next = bases_inc;
                    gc_next    = gc_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg  <= '0;
            run_begin_reg <= '0;
            in_run_reg    <= 1'b0;
            bases_reg     <= '0;
            gc_reg        <= '0;
            windows_reg   <= '0;
            total_reg     <= '0;
            sq_reg        <= '0;
        end
        else
        begin
            position_reg  <= position_next;
            run_begin_reg <= run_begin_next;
            in_run_reg    <= in_run_next;
            bases_reg     <= bases_next;
            gc_reg        <= gc_next;
            windows_reg   <= windows_next;
            total_reg     <= total_next;
            sq_reg        <= sq_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/gcwp_out_fifo.sv @@
// ----------------------------------------------------------------------------
// gcwp_out_fifo
// Small result queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gcwp_out_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire gcwp_pkg::res_push_t  push,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output gcwp_pkg::result_t         out_res,
    output logic                      room
);

    localparam int DEPTH = gcwp_pkg::FIFO_DEPTH;
    localparam int PTR_W = gcwp_pkg::FIFO_PTR_W;
    localparam int CNT_W = gcwp_pkg::FIFO_CNT_W;

    gcwp_pkg::result_t  mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, wr_ptr_plus1;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [1:0]         n_push;
    logic               pop;

    assign out_valid    = (count_reg != '0);
    assign out_res      = mem[rd_ptr_reg];
    assign pop          = out_valid && out_ready;
    assign room         = (count_reg <= CNT_W'(DEPTH - 2));
    assign n_push       = {1'b0, push.valid0} + {1'b0, push.valid1};
    assign wr_ptr_plus1 = wr_ptr_reg + {{(PTR_W-1){1'b0}}, 1'b1};
    assign wr_ptr_next  = wr_ptr_reg + PTR_W'(n_push);
    assign rd_ptr_next  = rd_ptr_reg + {{(PTR_W-1){1'b0}}, pop};
    assign count_next   = count_reg + CNT_W'(n_push) - {{(CNT_W-1){1'b0}}, pop};

    always_ff @(posedge clk)
    begin
        if (push.valid0)
        begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.valid1)
        begin
            mem[wr_ptr_plus1] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue count above depth");

    a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid1 |-> push.valid0)
        else $error("second result pushed without first");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid0 |-> (count_reg <= CNT_W'(DEPTH - 2)))
        else $error("result pushed without room for two");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("pending result lost during stall");
`endif

endmodule

`default_nettype wire

@@ rtl/gc_window_profiler_unit.sv @@
// ----------------------------------------------------------------------------
// gc_window_profiler_unit
// Streaming G/C window profiler with N-run reporting.
// ----------------------------------------------------------------------------
// Usage: send one ASCII base per beat on s_axis (tdata = base, tlast = last
// base of the sequence). Non-N bases fill windows of window_length bases;
// each full window yields a window result (tuser = 0) with its G/C count and
// saturating running sums of counts and squared counts. A maximal run of N
// bases yields a run result (tuser = 1) with start and end positions when a
// non-N base closes it or the sequence ends. m_axis tlast marks the last
// result caused by one base; a base yields zero, one or two results.
// Flow: a beat is held in an input register and processed once the result
// queue has room for two results; its results pass through the queue to
// m_axis, a second result after the first.
// Throughput is one base per cycle while m_axis does not stall and each base
// yields at most one result; bases yielding two results can fill the
// four-entry result queue, whose output is single-beat.
// Reset clears all sequence state and sets window_length to 1 (0 acts as 1).
// When m_axis stalls, results wait in the queue; s_axis_tready drops once the
// queue cannot take two more results, so nothing is lost.
// Write window_length only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module gc_window_profiler_unit #(
    parameter int POSITION_BITS = gcwp_pkg::POSITION_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    // Configuration
    input  wire logic           window_length_we,
    input  wire logic [15:0]    window_length_wdata,
    // Input beats
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [7:0]     s_axis_tdata,   // [7:0] base
    input  wire logic           s_axis_tlast,   // end_of_sequence
    // Result beats
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    // [31:0] window_index, [47:32] window_gc_count, [79:48] gc_running_sum,
    // [127:80] gc_square_sum, [159:128] run_start, [191:160] run_end
    output logic [191:0]        m_axis_tdata,
    output logic                m_axis_tuser,   // [0] kind
    output logic                m_axis_tlast    // last_of_run
);

    logic [gcwp_pkg::WIN_W-1:0]   window_length_reg;
    logic                         in_valid_reg, in_valid_next;
    logic [gcwp_pkg::BASE_W-1:0]  in_base_reg;
    logic                         in_eos_reg;
    logic                         s_accept, fire, room;
    gcwp_pkg::res_push_t          push;
    gcwp_pkg::result_t            out_res;

    // Process the held beat only when the queue can absorb two results.
    assign fire          = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = s_accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= 16'd1;
            in_valid_reg      <= 1'b0;
        end
        else
        begin
            if (window_length_we)
            begin
                window_length_reg <= window_length_wdata;
            end
            in_valid_reg <= in_valid_next;
        end
    end

    // Hold the input payload; it only loads on an accepted beat.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_base_reg <= s_axis_tdata;
            in_eos_reg  <= s_axis_tlast;
        end
    end

    gcwp_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .base            (in_base_reg),
        .end_of_sequence (in_eos_reg),
        .window_length   (window_length_reg),
        .push            (push)
    );

    gcwp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_res   (out_res),
        .room      (room)
    );

    assign m_axis_tdata = {out_res.run_end, out_res.run_start, out_res.gc_square_sum,
                           out_res.gc_running_sum, out_res.window_gc_count,
                           out_res.window_index};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last_of_run;

endmodule

`default_nettype wire
